>>> rtl/fcp_pkg.sv
`default_nettype none
package fcp_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 17;
   localparam int QDEPTH     = 4;
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam logic [16:0] SCALE_ONE = 17'd65536;

   typedef struct packed {
      logic signed [31:0] normal_in;
      logic signed [31:0] tangent_one_in;
      logic signed [31:0] tangent_two_in;
      logic [15:0]        friction_coeff;
      logic               frictionless;
      logic               last_contact;
   } req_type;

   typedef struct packed {
      logic [30:0]        normal_out;
      logic signed [31:0] tangent_one_out;
      logic signed [31:0] tangent_two_out;
      logic               last_out;
   } rsp_type;

   // classified contact held in the queue
   typedef struct packed {
      logic [30:0]        normal;
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic [15:0]        mu;
      logic               bypass;
      logic               last;
   } item_type;

   // fields riding along the back pipeline
   typedef struct packed {
      logic [30:0]        normal;
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic               bypass;
      logic               last;
   } carry_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } qstat_type;

endpackage
`default_nettype wire

>>> rtl/fcp_front.sv
`default_nettype none
module fcp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fcp_pkg::req_type req_data,
   output logic                  push,
   output fcp_pkg::item_type     push_item,
   input  wire logic             q_full
);

   logic              valid_ff;
   fcp_pkg::item_type item_ff;
   fcp_pkg::item_type item_in;

   assign req_ready = !valid_ff || !q_full;
   assign push      = valid_ff && !q_full;
   assign push_item = item_ff;

   always_comb begin
      item_in.normal = req_data.normal_in[31] ? 31'd0 : req_data.normal_in[30:0];
      item_in.t1     = req_data.tangent_one_in;
      item_in.t2     = req_data.tangent_two_in;
      item_in.mu     = req_data.friction_coeff;
      // zero tangent pair gives r = 0: pass through
      item_in.bypass = req_data.frictionless ||
                       (req_data.tangent_one_in == 32'sd0 &&
                        req_data.tangent_two_in == 32'sd0);
      item_in.last   = req_data.last_contact;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/fcp_queue.sv
`default_nettype none
module fcp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fcp_pkg::item_type push_item,
   input  wire logic              pop,
   output fcp_pkg::item_type      pop_item,
   output fcp_pkg::qstat_type     stat
);

   fcp_pkg::item_type mem_ff [fcp_pkg::QDEPTH];
   logic [fcp_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [fcp_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign stat.count = cnt_ff;
   assign stat.full  = (cnt_ff == fcp_pkg::QCNT_W'(fcp_pkg::QDEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_item   = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/fcp_back.sv
`default_nettype none
module fcp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire fcp_pkg::item_type q_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fcp_pkg::rsp_type       rsp_data
);

   localparam int NS = fcp_pkg::SQRT_STEPS;
   localparam int ND = fcp_pkg::DIV_STEPS;

   logic en;

   // squares and numerator
   logic                a_v_ff;
   fcp_pkg::carry_type  a_c_ff;
   logic [63:0]         a_sq1_ff, a_sq2_ff;
   logic [48:0]         a_num_ff;
   logic [31:0]         mag1, mag2;

   // square root chain, element 0 holds the sum
   logic                s_v_ff   [NS+1];
   fcp_pkg::carry_type  s_c_ff   [NS+1];
   logic [63:0]         s_rad_ff [NS+1];
   logic [33:0]         s_rem_ff [NS+1];
   logic [31:0]         s_root_ff[NS+1];
   logic [48:0]         s_num_ff [NS+1];

   // restoring divider chain
   logic                d_v_ff   [ND+1];
   fcp_pkg::carry_type  d_c_ff   [ND+1];
   logic [48:0]         d_rem_ff [ND+1];
   logic [31:0]         d_div_ff [ND+1];
   logic [16:0]         d_q_ff   [ND+1];
   logic                d_sat_ff [ND+1];

   // scaling products
   logic                e_v_ff;
   fcp_pkg::carry_type  e_c_ff;
   logic signed [49:0]  e_p1_ff, e_p2_ff;
   logic [16:0]         scale;

   logic                o_v_ff;
   fcp_pkg::rsp_type    o_ff;

   assign en        = !o_v_ff || rsp_ready;
   assign pop       = en && q_valid;
   assign rsp_valid = o_v_ff;
   assign rsp_data  = o_ff;

   assign mag1 = q_item.t1[31] ? 32'(-q_item.t1) : 32'(q_item.t1);
   assign mag2 = q_item.t2[31] ? 32'(-q_item.t2) : 32'(q_item.t2);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff    <= 1'b0;
         s_v_ff[0] <= 1'b0;
         d_v_ff[0] <= 1'b0;
         e_v_ff    <= 1'b0;
         o_v_ff    <= 1'b0;
      end else if (en) begin
         a_v_ff    <= q_valid;
         s_v_ff[0] <= a_v_ff;
         d_v_ff[0] <= s_v_ff[NS];
         e_v_ff    <= d_v_ff[ND];
         o_v_ff    <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_c_ff   <= '{normal: q_item.normal, t1: q_item.t1, t2: q_item.t2,
                       bypass: q_item.bypass, last: q_item.last};
         a_sq1_ff <= 64'(mag1) * 64'(mag1);
         a_sq2_ff <= 64'(mag2) * 64'(mag2);
         a_num_ff <= {47'(q_item.mu) * 47'(q_item.normal), 2'b00};

         s_c_ff[0]    <= a_c_ff;
         s_rad_ff[0]  <= a_sq1_ff + a_sq2_ff;
         s_rem_ff[0]  <= '0;
         s_root_ff[0] <= '0;
         s_num_ff[0]  <= a_num_ff;

         d_c_ff[0]   <= s_c_ff[NS];
         d_rem_ff[0] <= s_num_ff[NS];
         d_div_ff[0] <= s_root_ff[NS];
         d_q_ff[0]   <= '0;
         d_sat_ff[0] <= s_num_ff[NS] >= {s_root_ff[NS], 17'd0};

         e_c_ff  <= d_c_ff[ND];
         e_p1_ff <= $signed({1'b0, scale}) * d_c_ff[ND].t1;
         e_p2_ff <= $signed({1'b0, scale}) * d_c_ff[ND].t2;

         o_ff.normal_out      <= e_c_ff.normal;
         o_ff.tangent_one_out <= e_c_ff.bypass ? e_c_ff.t1 : e_p1_ff[47:16];
         o_ff.tangent_two_out <= e_c_ff.bypass ? e_c_ff.t2 : e_p2_ff[47:16];
         o_ff.last_out        <= e_c_ff.last;
      end
   end

   assign scale = (d_sat_ff[ND] || d_q_ff[ND] > fcp_pkg::SCALE_ONE) ?
                  fcp_pkg::SCALE_ONE : d_q_ff[ND];

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic [35:0] rem_sh, trial;
      logic        ge;
      assign rem_sh = {s_rem_ff[k], s_rad_ff[k][63:62]};
      assign trial  = {2'b00, s_root_ff[k], 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            s_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            s_v_ff[k+1] <= s_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_c_ff[k+1]    <= s_c_ff[k];
            s_num_ff[k+1]  <= s_num_ff[k];
            s_rad_ff[k+1]  <= {s_rad_ff[k][61:0], 2'b00};
            s_rem_ff[k+1]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            s_root_ff[k+1] <= {s_root_ff[k][30:0], ge};
         end
      end
   end

   for (genvar j = 0; j < ND; j++) begin : g_div
      localparam int BIT = ND - 1 - j;
      logic [48:0] sh;
      logic        take;
      assign sh   = 49'(d_div_ff[j]) << BIT;
      assign take = !d_sat_ff[j] && (d_rem_ff[j] >= sh);

      always_ff @(posedge clock) begin
         if (reset) begin
            d_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            d_v_ff[j+1] <= d_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_c_ff[j+1]   <= d_c_ff[j];
            d_div_ff[j+1] <= d_div_ff[j];
            d_sat_ff[j+1] <= d_sat_ff[j];
            d_rem_ff[j+1] <= take ? d_rem_ff[j] - sh : d_rem_ff[j];
            d_q_ff[j+1]   <= d_q_ff[j] | (take ? 17'(1) << BIT : 17'd0);
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/friction_cone_projection.sv
// channel | dir | handshake            | word
// req     | in  | req_valid/req_ready  | fcp_pkg::req_type
// rsp     | out | rsp_valid/rsp_ready  | fcp_pkg::rsp_type
// One contact accepted per cycle while the queue is not full, one result per
// contact, in order. Results pass through the 32-step square root and the
// 17-step divider pipelines. Synchronous reset empties the queue and all
// valid flags. A stalled rsp freezes the back pipeline; the 4-word queue
// lets the front keep taking words until it fills.
`default_nettype none
module friction_cone_projection (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fcp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fcp_pkg::rsp_type      rsp_data
);

   logic                push, pop;
   fcp_pkg::item_type   push_item, pop_item;
   fcp_pkg::qstat_type  qs;

   fcp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .push, .push_item, .q_full(qs.full)
   );

   fcp_queue u_queue (
      .clock, .reset, .push, .push_item, .pop, .pop_item, .stat(qs)
   );

   fcp_back u_back (
      .clock, .reset, .q_valid(!qs.empty), .q_item(pop_item), .pop,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      qs.count <= fcp_pkg::QCNT_W'(fcp_pkg::QDEPTH))
      else $error("queue count beyond depth");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> qs.full)
      else $error("front stalled with queue space");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && qs.empty))
      else $error("pop from empty queue");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

>>> sim/fcp_checker.sv
module fcp_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire fcp_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire fcp_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   fcp_pkg::rsp_type projected_q[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x = v;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] scale_by(input logic [16:0] s,
                                                   input logic signed [31:0] t);
      logic signed [63:0] prod;
      prod = $signed({47'd0, s}) * 64'(t);
      return 32'(prod >>> 16);
   endfunction

   function automatic fcp_pkg::rsp_type project_contact(input fcp_pkg::req_type c);
      fcp_pkg::rsp_type o;
      logic [31:0] n;
      logic [63:0] a1;
      logic [63:0] a2;
      logic [63:0] r;
      logic [63:0] q;
      n = c.normal_in[31] ? 32'd0 : c.normal_in;
      o.normal_out = n[30:0];
      o.tangent_one_out = c.tangent_one_in;
      o.tangent_two_out = c.tangent_two_in;
      o.last_out = c.last_contact;
      if (!c.frictionless) begin
         a1 = c.tangent_one_in[31] ? -64'(c.tangent_one_in) : 64'(c.tangent_one_in);
         a2 = c.tangent_two_in[31] ? -64'(c.tangent_two_in) : 64'(c.tangent_two_in);
         r = int_sqrt(a1 * a1 + a2 * a2);
         if (r != 0) begin
            q = (64'd4 * 64'(c.friction_coeff) * 64'(n)) / r;
            if (q > 64'(fcp_pkg::SCALE_ONE)) q = 64'(fcp_pkg::SCALE_ONE);
            o.tangent_one_out = scale_by(q[16:0], c.tangent_one_in);
            o.tangent_two_out = scale_by(q[16:0], c.tangent_two_in);
         end
      end
      return o;
   endfunction

   task automatic report(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending = projected_q.size();

   always @(posedge clock) begin
      fcp_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) projected_q.push_back(project_contact(req_data));
         if (rsp_valid && rsp_ready) begin
            if (projected_q.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               want = projected_q.pop_front();
               if (rsp_data.normal_out !== want.normal_out)
                  report($sformatf("normal %h want %h", rsp_data.normal_out, want.normal_out));
               if (rsp_data.tangent_one_out !== want.tangent_one_out)
                  report($sformatf("tangent one %h want %h", rsp_data.tangent_one_out,
                                   want.tangent_one_out));
               if (rsp_data.tangent_two_out !== want.tangent_two_out)
                  report($sformatf("tangent two %h want %h", rsp_data.tangent_two_out,
                                   want.tangent_two_out));
               if (rsp_data.last_out !== want.last_out)
                  report($sformatf("last %b want %b", rsp_data.last_out, want.last_out));
            end
         end
      end
   end
endmodule

>>> sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   fcp_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   fcp_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   int               cycle_count;
   bit               calm;

   friction_cone_projection i_dut (.*);

   fcp_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 200000) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 34);
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(2000000)) - 1000000);
         3: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // valid is left high after acceptance; the next idle gap or the caller drops it
   task automatic send_contact(input fcp_pkg::req_type c);
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_directed(input logic [31:0] n, input logic [31:0] t1,
                                input logic [31:0] t2, input logic [15:0] mu,
                                input logic fl, input logic last);
      fcp_pkg::req_type c;
      c.normal_in = n;
      c.tangent_one_in = t1;
      c.tangent_two_in = t2;
      c.friction_coeff = mu;
      c.frictionless = fl;
      c.last_contact = last;
      send_contact(c);
   endtask

   initial begin
      fcp_pkg::req_type c;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_directed(32'hffff_0000, 32'h0001_0000, 32'h0002_0000, 16'h4000, 1'b0, 1'b0);
      send_directed(32'hffff_0000, 32'h0001_0000, 32'h0002_0000, 16'h4000, 1'b1, 1'b1);
      send_directed(32'h0001_0000, 32'h0003_0000, 32'hfffc_0000, 16'h4000, 1'b1, 1'b0);
      send_directed(32'h0001_0000, 32'h0, 32'h0, 16'h4000, 1'b0, 1'b1);
      send_directed(32'h0, 32'h0003_0000, 32'hfffc_0000, 16'h4000, 1'b0, 1'b0);
      send_directed(32'h0001_0000, 32'h0003_0000, 32'hfffc_0000, 16'h4000, 1'b0, 1'b0);
      send_directed(32'h0100_0000, 32'h0003_0000, 32'hfffc_0000, 16'h2000, 1'b0, 1'b1);
      send_directed(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 16'hffff, 1'b0, 1'b0);
      send_directed(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 1'b0, 1'b1);
      send_directed(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b0, 1'b0);
      send_directed(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 16'h0001, 1'b0, 1'b0);
      send_directed(32'h0001_0000, 32'h0, 32'hffff_ffff, 16'hffff, 1'b0, 1'b1);
      for (int i = 0; i < 950; i++) begin
         if (i == 300) calm = 1'b1;
         if (i == 450) calm = 1'b0;
         if (i == 600) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         c.normal_in = pick_word();
         c.tangent_one_in = pick_word();
         c.tangent_two_in = pick_word();
         c.friction_coeff = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000));
         c.frictionless = ($urandom_range(4) == 0);
         c.last_contact = 1'($urandom_range(1));
         send_contact(c);
      end
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
